### sv/fcvm_pkg.sv
// ----------------------------------------------------------------------------
// Fly camera view matrix package
// Shared constants, the arctangent table and fixed-point helpers.
// ----------------------------------------------------------------------------
package fcvm_pkg;

  localparam int unsigned TrigIterDefault = 16;
  localparam int unsigned AtanCount       = 24;
  localparam logic signed [33:0] CordicGain = 34'sd652032874;

  function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
    logic signed [33:0] r;
    unique case (idx)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = 34'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

### sv/fly_camera_view_matrix_top.sv
// ----------------------------------------------------------------------------
// Fly camera view matrix
// Angles, speeds and a time step in; four Q16.16 matrix columns out.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid_i/in_stall_o  angles, speeds, time step
// out      output     out_valid_o/out_stall_i column_index, elem_a..d, last
//
// An item runs from accept to the next accept through the CORDIC loop for
// elevation and then azimuth, shared multiplier steps 0 to 7, the square
// root, the divider and multiplier steps 8 to 29 (30 steps in all), then
// the output of four columns; the first is registered at the last step.
// Reset clears the position and the sequencer. The block takes no item
// until all four columns of the previous item have been taken.
// A stalled column holds in the output register.
module fly_camera_view_matrix_top #(
  parameter int unsigned TRIG_ITERATIONS = fcvm_pkg::TrigIterDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic        [15:0] elevation_i,
  input  logic        [15:0] azimuth_i,
  input  logic signed [15:0] lateral_speed_i,
  input  logic signed [15:0] vertical_speed_i,
  input  logic signed [15:0] forward_speed_i,
  input  logic        [15:0] time_step_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic        [1:0]  column_index_o,
  output logic signed [31:0] elem_a_o,
  output logic signed [31:0] elem_b_o,
  output logic signed [31:0] elem_c_o,
  output logic signed [31:0] elem_d_o,
  output logic               last_column_o
);

  localparam int unsigned NIter = (TRIG_ITERATIONS < 1) ? 1 :
      (TRIG_ITERATIONS > fcvm_pkg::AtanCount) ? fcvm_pkg::AtanCount : TRIG_ITERATIONS;

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StCord = 4'd1;
  localparam logic [3:0] StMul  = 4'd2;
  localparam logic [3:0] StSqrt = 4'd3;
  localparam logic [3:0] StDiv  = 4'd4;
  localparam logic [3:0] StOut  = 4'd5;

  logic [3:0] st_q, st_d;
  logic [5:0] cnt_q;
  logic [6:0] step_q;
  logic       ang_q;

  logic [15:0] elev_q, azim_q, dt_q;
  logic signed [15:0] lat_q, ver_q, fwd_q;
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic flip_q;
  logic signed [33:0] se_q, ce_q, sa_q, ca_q;
  logic signed [33:0] atx_q, atz_q, upx_q, upy_q, upz_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic signed [65:0] acc_q;
  logic signed [65:0] tx_q, ty_q, tz_q;
  logic [63:0] rem_q, res_q;
  logic [62:0] bit_q;
  logic [63:0] div_rem_q;
  logic [60:0] quo_q;
  logic [63:0] m_q;
  logic signed [33:0] scale_q;
  logic [1:0] col_q;
  logic out_valid_q;
  logic signed [31:0] ea_q, eb_q, ec_q, ed_q;

  // Shared multiplier operands.
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  assign prod = ma * mb;

  logic [4:0] it;
  logic signed [33:0] dx, dy;
  assign it = cnt_q[4:0];
  assign dx = cy_q >>> it;
  assign dy = cx_q >>> it;

  function automatic logic signed [33:0] rq30(input logic signed [67:0] p);
    logic signed [67:0] t;
    t = (p + 68'sd536870912) >>> 30;
    return t[33:0];
  endfunction

  function automatic logic signed [31:0] q16(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd8192) >>> 14;
    return t[31:0];
  endfunction

  // Multiply step schedule.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step_q)
      7'd0: begin ma = ce_q; mb = sa_q; end
      7'd1: begin ma = ce_q; mb = ca_q; end
      7'd2: begin ma = se_q; mb = sa_q; end
      7'd3: begin ma = se_q; mb = ca_q; end
      7'd4: begin ma = atx_q; mb = sa_q; end
      7'd5: begin ma = atz_q; mb = ca_q; end
      7'd6: begin ma = se_q; mb = se_q; end
      7'd7: begin ma = upy_q; mb = upy_q; end
      7'd8: begin ma = upx_q; mb = scale_q; end
      7'd9: begin ma = upy_q; mb = scale_q; end
      7'd10: begin ma = upz_q; mb = scale_q; end
      7'd11: begin ma = 34'(lat_q); mb = ca_q; end
      7'd12: begin ma = 34'(ver_q); mb = upx_q; end
      7'd13: begin ma = 34'(fwd_q); mb = atx_q; end
      7'd14: begin ma = acc_q[47:14]; mb = {18'd0, dt_q}; end
      7'd15: begin ma = 34'(ver_q); mb = upy_q; end
      7'd16: begin ma = 34'(fwd_q); mb = se_q; end
      7'd17: begin ma = acc_q[47:14]; mb = {18'd0, dt_q}; end
      7'd18: begin ma = 34'(lat_q); mb = sa_q; end
      7'd19: begin ma = 34'(ver_q); mb = upz_q; end
      7'd20: begin ma = 34'(fwd_q); mb = atz_q; end
      7'd21: begin ma = acc_q[47:14]; mb = {18'd0, dt_q}; end
      7'd22: begin ma = 34'(px_q); mb = ca_q; end
      7'd23: begin ma = 34'(pz_q); mb = sa_q; end
      7'd24: begin ma = 34'(px_q); mb = upx_q; end
      7'd25: begin ma = 34'(py_q); mb = upy_q; end
      7'd26: begin ma = 34'(pz_q); mb = upz_q; end
      7'd27: begin ma = 34'(px_q); mb = atx_q; end
      7'd28: begin ma = 34'(py_q); mb = se_q; end
      7'd29: begin ma = 34'(pz_q); mb = atz_q; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  logic signed [65:0] pfl;
  assign pfl = 66'(prod >>> 14);

  logic [63:0] trial;
  assign trial = res_q + {1'b0, bit_q};

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (in_valid_i) st_d = StCord;
      StCord: if (cnt_q == 6'(NIter - 1) && ang_q) st_d = StMul;
      StMul:  if (step_q == 7'd7) st_d = StSqrt;
              else if (step_q == 7'd29) st_d = StOut;
      StSqrt: if (bit_q == '0) st_d = StDiv;
      StDiv:  if (cnt_q == 6'd60) st_d = StMul;
      StOut:  if (!out_stall_i && col_q == 2'd3) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign in_stall_o = (st_q != StIdle);

  logic [64:0] dtr;
  logic [5:0] dbit;
  assign dbit = 6'd60 - cnt_q;
  assign dtr = {div_rem_q, (dbit == 6'd60)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      cnt_q <= '0;
      step_q <= '0;
      ang_q <= 1'b0;
      px_q <= '0;
      py_q <= '0;
      pz_q <= '0;
      col_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        StIdle: begin
          if (in_valid_i) begin
            elev_q <= elevation_i;
            azim_q <= azimuth_i;
            lat_q <= lateral_speed_i;
            ver_q <= vertical_speed_i;
            fwd_q <= forward_speed_i;
            dt_q <= time_step_i;
            cnt_q <= '0;
            ang_q <= 1'b0;
            step_q <= '0;
            cx_q <= fcvm_pkg::CordicGain;
            cy_q <= '0;
            cz_q <= 34'(signed'({elevation_i ^ {(elevation_i[15:14] == 2'b01 ||
                     elevation_i[15:14] == 2'b10), 15'd0}, 16'd0}));
            flip_q <= (elevation_i[15:14] == 2'b01 || elevation_i[15:14] == 2'b10);
          end
        end
        StCord: begin
          if (cnt_q == 6'(NIter - 1) && !ang_q) begin
            ce_q <= flip_q ? -(cx_q + (cz_q[33] ? dx : -dx))
                           : cx_q + (cz_q[33] ? dx : -dx);
            se_q <= flip_q ? -(cy_q + (cz_q[33] ? -dy : dy))
                           : cy_q + (cz_q[33] ? -dy : dy);
            ang_q <= 1'b1;
            cnt_q <= '0;
            cx_q <= fcvm_pkg::CordicGain;
            cy_q <= '0;
            cz_q <= 34'(signed'({azim_q ^ {(azim_q[15:14] == 2'b01 ||
                     azim_q[15:14] == 2'b10), 15'd0}, 16'd0}));
            flip_q <= (azim_q[15:14] == 2'b01 || azim_q[15:14] == 2'b10);
          end else begin
            if (!cz_q[33]) begin
              cx_q <= cx_q - dx;
              cy_q <= cy_q + dy;
              cz_q <= cz_q - fcvm_pkg::atan_turn(it);
            end else begin
              cx_q <= cx_q + dx;
              cy_q <= cy_q - dy;
              cz_q <= cz_q + fcvm_pkg::atan_turn(it);
            end
            if (cnt_q == 6'(NIter - 1)) begin
              ca_q <= flip_q ? -(cx_q + (cz_q[33] ? dx : -dx))
                             : cx_q + (cz_q[33] ? dx : -dx);
              sa_q <= flip_q ? -(cy_q + (cz_q[33] ? -dy : dy))
                             : cy_q + (cz_q[33] ? -dy : dy);
            end else begin
              cnt_q <= cnt_q + 6'd1;
            end
          end
        end
        StMul: begin
          step_q <= step_q + 7'd1;
          unique case (step_q)
            7'd0: atx_q <= rq30(prod);
            7'd1: atz_q <= -rq30(prod);
            7'd2: upx_q <= -rq30(prod);
            7'd3: upz_q <= rq30(prod);
            7'd4: acc_q <= 66'(prod);
            7'd5: upy_q <= rq30(68'(acc_q) - prod);
            7'd6: acc_q <= 66'(prod);
            7'd7: begin
              rem_q <= acc_q[63:0] + prod[63:0];
              res_q <= '0;
              bit_q <= 63'd1 << 62;
              cnt_q <= '0;
            end
            7'd8: upx_q <= rq30(prod);
            7'd9: upy_q <= rq30(prod);
            7'd10: upz_q <= rq30(prod);
            7'd11, 7'd15, 7'd18: acc_q <= 66'(prod);
            7'd12, 7'd13, 7'd16, 7'd19, 7'd20: acc_q <= acc_q + 66'(prod);
            7'd14: px_q <= fcvm_pkg::sat32(66'(px_q) + 66'(prod >>> 24));
            7'd17: py_q <= fcvm_pkg::sat32(66'(py_q) + 66'(prod >>> 24));
            7'd21: pz_q <= fcvm_pkg::sat32(66'(pz_q) + 66'(prod >>> 24));
            7'd22, 7'd24, 7'd27: acc_q <= pfl;
            7'd23: tx_q <= acc_q + pfl;
            7'd25, 7'd28: acc_q <= acc_q + pfl;
            7'd26: ty_q <= acc_q + pfl;
            7'd29: begin
              tz_q <= acc_q + pfl;
              col_q <= '0;
              out_valid_q <= 1'b1;
              ea_q <= q16(ca_q);
              eb_q <= q16(upx_q);
              ec_q <= -q16(atx_q);
              ed_q <= '0;
            end
            default: ;
          endcase
        end
        StSqrt: begin
          if (bit_q != '0) begin
            if (rem_q >= trial) begin
              rem_q <= rem_q - trial;
              res_q <= (res_q >> 1) + {1'b0, bit_q};
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end else begin
            m_q <= res_q;
            div_rem_q <= '0;
            quo_q <= '0;
            cnt_q <= '0;
          end
        end
        StDiv: begin
          // Restoring division of 2^60 by m, one quotient bit a cycle.
          if (dtr >= {1'b0, m_q}) begin
            div_rem_q <= 64'(dtr - {1'b0, m_q});
            quo_q <= {quo_q[59:0], 1'b1};
          end else begin
            div_rem_q <= dtr[63:0];
            quo_q <= {quo_q[59:0], 1'b0};
          end
          if (cnt_q == 6'd60) begin
            if (m_q == '0 || (dtr >= {1'b0, m_q} ? {quo_q[59:0], 1'b1} : {quo_q[59:0], 1'b0})
                > 61'd2147483648) begin
              scale_q <= 34'sd2147483648;
            end else begin
              scale_q <= dtr >= {1'b0, m_q} ? 34'({quo_q[31:0], 1'b1})
                                            : 34'({quo_q[31:0], 1'b0});
            end
          end else begin
            cnt_q <= cnt_q + 6'd1;
          end
        end
        StOut: begin
          if (!out_stall_i) begin
            col_q <= col_q + 2'd1;
            unique case (col_q)
              2'd0: begin
                ea_q <= '0; eb_q <= q16(upy_q); ec_q <= -q16(se_q); ed_q <= '0;
              end
              2'd1: begin
                ea_q <= q16(sa_q); eb_q <= q16(upz_q); ec_q <= -q16(atz_q); ed_q <= '0;
              end
              2'd2: begin
                ea_q <= fcvm_pkg::sat32(-((tx_q + 66'sd32768) >>> 16));
                eb_q <= fcvm_pkg::sat32(-((ty_q + 66'sd32768) >>> 16));
                ec_q <= fcvm_pkg::sat32((tz_q + 66'sd32768) >>> 16);
                ed_q <= 32'sd65536;
              end
              default: out_valid_q <= 1'b0;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign column_index_o = col_q;
  assign elem_a_o = ea_q;
  assign elem_b_o = eb_q;
  assign elem_c_o = ec_q;
  assign elem_d_o = ed_q;
  assign last_column_o = (col_q == 2'd3);

`ifndef ASSERT_OFF
  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> st_q == StOut) else $error("result outside output phase");
  a_busy_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during output");
  a_col_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_column_o) |=> !out_valid_o)
    else $error("result after last column");
`endif

endmodule
